// ===== hw/rtl/lts_pkg.sv =====
package lts_pkg;

    localparam int MaxLine = 1024;
    localparam int ColW    = $clog2(MaxLine + 1);   // end column, 0..MaxLine
    localparam int StartW  = $clog2(MaxLine);       // start column, 0..MaxLine-1

    localparam logic [ColW-1:0]   ColMax   = ColW'(MaxLine);
    localparam logic [StartW-1:0] StartMax = StartW'(MaxLine - 1);

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_IDENT   = 4'd1,
        M_INT     = 4'd2,
        M_FRAC    = 4'd3,
        M_EQ      = 4'd4,
        M_LT      = 4'd5,
        M_GT      = 4'd6,
        M_BANG    = 4'd7,
        M_COMMENT = 4'd8,
        M_DEAD    = 4'd9
    } t_mode;

    // token kinds
    localparam logic [3:0] KindIdent  = 4'd0;
    localparam logic [3:0] KindNumber = 4'd1;
    localparam logic [3:0] KindSemi   = 4'd2;
    localparam logic [3:0] KindLparen = 4'd3;
    localparam logic [3:0] KindRparen = 4'd4;
    localparam logic [3:0] KindPrint  = 4'd5;
    localparam logic [3:0] KindOper   = 4'd6;
    localparam logic [3:0] KindComma  = 4'd7;
    localparam logic [3:0] KindLbrace = 4'd8;
    localparam logic [3:0] KindRbrace = 4'd9;
    localparam logic [3:0] KindError  = 4'd10;
    localparam logic [3:0] KindEol    = 4'd11;

    // operator codes
    localparam logic [3:0] OpNone = 4'd0;
    localparam logic [3:0] OpMul  = 4'd0;
    localparam logic [3:0] OpDiv  = 4'd1;
    localparam logic [3:0] OpAdd  = 4'd2;
    localparam logic [3:0] OpSub  = 4'd3;
    localparam logic [3:0] OpPow  = 4'd4;
    localparam logic [3:0] OpAsg  = 4'd5;
    localparam logic [3:0] OpEq   = 4'd6;
    localparam logic [3:0] OpLt   = 4'd7;
    localparam logic [3:0] OpLe   = 4'd8;
    localparam logic [3:0] OpGt   = 4'd9;
    localparam logic [3:0] OpGe   = 4'd10;
    localparam logic [3:0] OpNe   = 4'd11;

    // character codes
    localparam logic [7:0] ChTab    = 8'd9;
    localparam logic [7:0] ChCr     = 8'd13;
    localparam logic [7:0] ChSpace  = 8'd32;
    localparam logic [7:0] ChLbrack = 8'h5B;
    localparam logic [7:0] ChSemi   = 8'h3B;
    localparam logic [7:0] ChLparen = 8'h28;
    localparam logic [7:0] ChRparen = 8'h29;
    localparam logic [7:0] ChHash   = 8'h23;
    localparam logic [7:0] ChComma  = 8'h2C;
    localparam logic [7:0] ChLbrace = 8'h7B;
    localparam logic [7:0] ChRbrace = 8'h7D;
    localparam logic [7:0] ChStar   = 8'h2A;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChPlus   = 8'h2B;
    localparam logic [7:0] ChMinus  = 8'h2D;
    localparam logic [7:0] ChCaret  = 8'h5E;
    localparam logic [7:0] ChEqual  = 8'h3D;
    localparam logic [7:0] ChLess   = 8'h3C;
    localparam logic [7:0] ChGreat  = 8'h3E;
    localparam logic [7:0] ChBang   = 8'h21;
    localparam logic [7:0] ChDot    = 8'h2E;
    localparam logic [7:0] ChQuote  = 8'h27;
    localparam logic [7:0] ChUnder  = 8'h5F;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChNine   = 8'h39;
    localparam logic [7:0] ChLowA   = 8'h61;
    localparam logic [7:0] ChLowZ   = 8'h7A;
    localparam logic [7:0] ChUpA    = 8'h41;
    localparam logic [7:0] ChUpZ    = 8'h5A;

    typedef struct packed {
        logic        action;
        logic [7:0]  char_code;
        logic [15:0] line_no;
    } t_in_item;

    typedef struct packed {
        logic [3:0]        token_kind;
        logic [3:0]        op_code;
        logic [StartW-1:0] start_col;
        logic [ColW-1:0]   end_col;
        logic [15:0]       token_line;
        logic              last_of_run;
    } t_out_item;

    typedef struct packed {
        t_mode             mode;
        logic [StartW-1:0] tok_start;
        logic [ColW-1:0]   column;
    } t_scan_state;

    typedef struct packed {
        logic [1:0]  cnt;
        t_out_item   res0;
        t_out_item   res1;
        t_scan_state nxt;
    } t_step_out;

endpackage

// ===== hw/rtl/lts_if.sv =====
interface lts_in_if
    import lts_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lts_out_if
    import lts_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lts_step.sv =====
module lts_step
    import lts_pkg::*;
(
    input  t_scan_state i_state,
    input  t_in_item    i_item,
    output t_step_out   o_step
);

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= ChZero) && (c <= ChNine);
    endfunction

    function automatic logic f_is_alpha(input logic [7:0] c);
        return ((c >= ChLowA) && (c <= ChLowZ)) || ((c >= ChUpA) && (c <= ChUpZ))
            || (c == ChUnder);
    endfunction

    function automatic logic f_is_space(input logic [7:0] c);
        return ((c >= ChTab) && (c <= ChCr)) || (c == ChSpace);
    endfunction

    function automatic t_out_item f_res(input logic [3:0] kind, input logic [3:0] op,
                                        input logic [StartW-1:0] s,
                                        input logic [ColW-1:0] e,
                                        input logic [15:0] line);
        t_out_item r;
        r.token_kind  = kind;
        r.op_code     = op;
        r.start_col   = s;
        r.end_col     = e;
        r.token_line  = line;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    logic [ColW-1:0]   pos;
    logic [ColW-1:0]   e2;
    logic [StartW-1:0] s_here;
    logic [ColW-1:0]   s_end;      // pending start + 1
    logic [7:0]        c;
    logic [15:0]       line;
    logic              done;

    // pending-token flush
    logic              fl_v;
    t_out_item         fl_r;

    // fresh character: single-char token, error, or start of a longer token
    logic              fr_v;
    t_out_item         fr_r;
    t_mode             fr_mode;
    logic              fr_start;

    // token finished in place (two-char ops, bang)
    logic              dn_v;
    t_out_item         dn_r;
    t_mode             dn_mode;

    logic              sec_v;
    t_out_item         sec_r;

    assign c      = i_item.char_code;
    assign line   = i_item.line_no;
    assign pos    = i_state.column;
    assign e2     = (pos >= ColMax) ? ColMax : pos + ColW'(1);
    assign s_here = (pos > ColW'(StartMax)) ? StartMax : pos[StartW-1:0];
    assign s_end  = ColW'(i_state.tok_start) + ColW'(1);

    always_comb begin
        fl_v    = 1'b1;
        fl_r    = f_res(KindIdent, OpNone, i_state.tok_start, pos, line);
        unique case (i_state.mode)
            M_IDENT: fl_r = f_res(KindIdent, OpNone, i_state.tok_start, pos, line);
            M_INT, M_FRAC: fl_r = f_res(KindNumber, OpNone, i_state.tok_start, pos, line);
            M_EQ: fl_r = f_res(KindOper, OpAsg, i_state.tok_start, s_end, line);
            M_LT: fl_r = f_res(KindOper, OpLt, i_state.tok_start, s_end, line);
            M_GT: fl_r = f_res(KindOper, OpGt, i_state.tok_start, s_end, line);
            M_BANG: fl_r = f_res(KindError, OpNone, i_state.tok_start, s_end, line);
            default: fl_v = 1'b0;
        endcase
    end

    always_comb begin
        fr_v     = 1'b0;
        fr_mode  = M_IDLE;
        fr_start = 1'b0;
        fr_r     = f_res(KindError, OpNone, s_here, e2, line);
        if (f_is_space(c)) begin
            fr_v = 1'b0;
        end else if (c == ChLbrack) begin
            fr_mode = M_COMMENT;
        end else if (f_is_alpha(c)) begin
            fr_mode  = M_IDENT;
            fr_start = 1'b1;
        end else if (f_is_digit(c)) begin
            fr_mode  = M_INT;
            fr_start = 1'b1;
        end else begin
            fr_v = 1'b1;
            unique case (c)
                ChSemi:   fr_r = f_res(KindSemi, OpNone, s_here, e2, line);
                ChLparen: fr_r = f_res(KindLparen, OpNone, s_here, e2, line);
                ChRparen: fr_r = f_res(KindRparen, OpNone, s_here, e2, line);
                ChHash:   fr_r = f_res(KindPrint, OpNone, s_here, e2, line);
                ChComma:  fr_r = f_res(KindComma, OpNone, s_here, e2, line);
                ChLbrace: fr_r = f_res(KindLbrace, OpNone, s_here, e2, line);
                ChRbrace: fr_r = f_res(KindRbrace, OpNone, s_here, e2, line);
                ChStar:   fr_r = f_res(KindOper, OpMul, s_here, e2, line);
                ChSlash:  fr_r = f_res(KindOper, OpDiv, s_here, e2, line);
                ChPlus:   fr_r = f_res(KindOper, OpAdd, s_here, e2, line);
                ChMinus:  fr_r = f_res(KindOper, OpSub, s_here, e2, line);
                ChCaret:  fr_r = f_res(KindOper, OpPow, s_here, e2, line);
                ChEqual: begin
                    fr_v = 1'b0; fr_mode = M_EQ; fr_start = 1'b1;
                end
                ChLess: begin
                    fr_v = 1'b0; fr_mode = M_LT; fr_start = 1'b1;
                end
                ChGreat: begin
                    fr_v = 1'b0; fr_mode = M_GT; fr_start = 1'b1;
                end
                ChBang: begin
                    fr_v = 1'b0; fr_mode = M_BANG; fr_start = 1'b1;
                end
                default: fr_mode = M_DEAD;   // unknown byte: error, drop rest of line
            endcase
        end
    end

    // character consumed by the current mode without a fresh start
    always_comb begin
        done    = 1'b0;
        dn_v    = 1'b0;
        dn_mode = i_state.mode;
        dn_r    = f_res(KindOper, OpNe, i_state.tok_start, e2, line);
        unique case (i_state.mode)
            M_IDENT: done = f_is_alpha(c) || f_is_digit(c) || (c == ChQuote);
            M_INT: begin
                done = f_is_digit(c) || (c == ChDot);
                if (c == ChDot) dn_mode = M_FRAC;
            end
            M_FRAC: done = f_is_digit(c);
            M_EQ, M_LT, M_GT: begin
                if (c == ChEqual) begin
                    done    = 1'b1;
                    dn_v    = 1'b1;
                    dn_mode = M_IDLE;
                    if (i_state.mode == M_EQ) begin
                        dn_r = f_res(KindOper, OpEq, i_state.tok_start, e2, line);
                    end else if (i_state.mode == M_LT) begin
                        dn_r = f_res(KindOper, OpLe, i_state.tok_start, e2, line);
                    end else begin
                        dn_r = f_res(KindOper, OpGe, i_state.tok_start, e2, line);
                    end
                end
            end
            M_BANG: begin
                done = 1'b1;
                dn_v = 1'b1;
                if (c == ChEqual) begin
                    dn_mode = M_IDLE;
                end else begin
                    dn_r    = f_res(KindError, OpNone, i_state.tok_start, s_end, line);
                    dn_mode = M_DEAD;
                end
            end
            M_COMMENT, M_DEAD: done = 1'b1;
            default: done = 1'b0;
        endcase
    end

    always_comb begin
        if (i_item.action) begin
            sec_v = 1'b1;
            sec_r = f_res(KindEol, OpNone, s_here, pos, line);
        end else if (done) begin
            sec_v = dn_v;
            sec_r = dn_r;
        end else begin
            sec_v = fr_v;
            sec_r = fr_r;
        end
    end

    // next state, then results: flush (if any) comes first, then the second source
    always_comb begin
        logic first_v;
        o_step.nxt = i_state;
        if (i_item.action) begin
            o_step.nxt.mode      = M_IDLE;
            o_step.nxt.tok_start = '0;
            o_step.nxt.column    = '0;
        end else begin
            o_step.nxt.column = e2;
            if (done) begin
                o_step.nxt.mode = dn_mode;
            end else begin
                o_step.nxt.mode = fr_mode;
                if (fr_start) o_step.nxt.tok_start = s_here;
            end
        end

        first_v = fl_v && (i_item.action || !done);
        o_step.cnt  = 2'(first_v) + 2'(sec_v);
        o_step.res0 = first_v ? fl_r : sec_r;
        o_step.res0.last_of_run = !(first_v && sec_v);
        o_step.res1 = sec_r;
        o_step.res1.last_of_run = 1'b1;
    end

endmodule

// ===== hw/rtl/line_token_scanner_core.sv =====
// Channel  Port    Dir  Payload
// input    i_in    in   action, char_code, line_no
// output   o_out   out  token_kind, op_code, start_col, end_col, token_line, last_of_run
//
// One item per cycle while the output is not stalled: the scan step is decoded
// in the accept cycle and its zero, one or two tokens land in a two-entry
// result register. An item that produces two tokens holds the input off while
// the result register drains; the result register sets the rate.
// Reset (synchronous, active low) returns the scanner to idle at column 0
// and empties the result register. A stalled output holds its token.
module line_token_scanner_core
    import lts_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    lts_in_if.sink        i_in,
    lts_out_if.source     o_out
);

    t_scan_state r_state, n_state;
    logic [1:0]  r_cnt, n_cnt;
    t_out_item   r_res [2];
    t_out_item   n_res [2];
    t_step_out   step;
    logic        acc;
    logic        take;

    lts_step u_step (
        .i_state (r_state),
        .i_item  (i_in.data),
        .o_step  (step)
    );

    assign i_in.ready  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);
    assign o_out.valid = (r_cnt != 2'd0);
    assign o_out.data  = r_res[0];
    assign acc  = i_in.valid && i_in.ready;
    assign take = o_out.valid && o_out.ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_res   = r_res;
        if (acc) begin
            n_state  = step.nxt;
            n_cnt    = step.cnt;
            n_res[0] = step.res0;
            n_res[1] = step.res1;
        end else if (take) begin
            n_res[0] = r_res[1];
            n_cnt    = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode      <= M_IDLE;
            r_state.tok_start <= '0;
            r_state.column    <= '0;
            r_cnt             <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result count out of range");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (!r_res[0].last_of_run && r_res[1].last_of_run))
        else $error("two-token run marked wrong");

    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in.data.action) |=> (r_state.mode == M_IDLE && r_state.column == '0))
        else $error("end of line did not clear scan state");

    a_col_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.column <= ColMax)
        else $error("column beyond line limit");

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import lts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    StallLimit = 2000;
    localparam int    HoldCycles = 300;
    localparam string Letters    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string NameChars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789'";
    localparam string SingleOps  = "*/+-^=<>";
    localparam string PairLeads  = "=<>!";
    localparam string Punct      = "(){};,#";

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lts_in_if  in_ch ();
    lts_out_if out_ch ();

    line_token_scanner_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    int src_idle_pct  = 30;
    int snk_idle_pct  = 63;
    int hold_request  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int mismatches    = 0;
    int items_sent    = 0;
    int lines_sent    = 0;
    int chars_in_line = 0;
    int tokens_seen   = 0;
    int capped_tokens = 0;

    // scanner mirror
    t_mode             scan_mode_q = M_IDLE;
    logic [StartW-1:0] tok_start_q = '0;
    logic [ColW-1:0]   column_q    = '0;
    t_out_item         expected_tokens[$];
    t_out_item         step_tokens[$];

    function automatic logic [ColW-1:0] sat_end(int unsigned v);
        return (v > MaxLine) ? ColMax : ColW'(v);
    endfunction

    function automatic logic [StartW-1:0] sat_start(int unsigned v);
        return (v > MaxLine - 1) ? StartMax : StartW'(v);
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return (c >= ChTab && c <= ChCr) || c == ChSpace;
    endfunction

    function automatic bit is_digit_ch(logic [7:0] c);
        return c >= ChZero && c <= ChNine;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= ChLowA && c <= ChLowZ) || (c >= ChUpA && c <= ChUpZ) || c == ChUnder;
    endfunction

    function automatic bit is_name_ch(logic [7:0] c);
        return is_letter(c) || is_digit_ch(c) || c == ChQuote;
    endfunction

    function automatic void push_token(logic [3:0] kind, logic [3:0] op, logic [StartW-1:0] s,
                                       logic [ColW-1:0] e, logic [15:0] ln);
        step_tokens.push_back('{token_kind: kind, op_code: op, start_col: s, end_col: e,
                                token_line: ln, last_of_run: 1'b0});
    endfunction

    // finish whatever token is open; names and numbers end at end_c
    function automatic void close_pending(logic [ColW-1:0] end_c, logic [15:0] ln);
        case (scan_mode_q)
            M_IDENT: push_token(KindIdent, OpNone, tok_start_q, end_c, ln);
            M_INT, M_FRAC: push_token(KindNumber, OpNone, tok_start_q, end_c, ln);
            M_EQ: push_token(KindOper, OpAsg, tok_start_q, sat_end(tok_start_q + 1), ln);
            M_LT: push_token(KindOper, OpLt, tok_start_q, sat_end(tok_start_q + 1), ln);
            M_GT: push_token(KindOper, OpGt, tok_start_q, sat_end(tok_start_q + 1), ln);
            M_BANG: begin
                push_token(KindError, OpNone, tok_start_q, sat_end(tok_start_q + 1), ln);
                scan_mode_q = M_DEAD;
                return;
            end
            default: return;
        endcase
        scan_mode_q = M_IDLE;
    endfunction

    function automatic void start_fresh(logic [7:0] c, logic [ColW-1:0] pos, logic [15:0] ln);
        logic [StartW-1:0] s;
        logic [ColW-1:0]   e;
        s = sat_start(pos);
        e = sat_end(pos + 1);
        if (is_blank(c)) return;
        if (c == ChLbrack) begin
            scan_mode_q = M_COMMENT;
            return;
        end
        if (is_letter(c)) begin
            scan_mode_q = M_IDENT;
            tok_start_q = s;
            return;
        end
        if (is_digit_ch(c)) begin
            scan_mode_q = M_INT;
            tok_start_q = s;
            return;
        end
        case (c)
            ChSemi:   push_token(KindSemi, OpNone, s, e, ln);
            ChLparen: push_token(KindLparen, OpNone, s, e, ln);
            ChRparen: push_token(KindRparen, OpNone, s, e, ln);
            ChHash:   push_token(KindPrint, OpNone, s, e, ln);
            ChComma:  push_token(KindComma, OpNone, s, e, ln);
            ChLbrace: push_token(KindLbrace, OpNone, s, e, ln);
            ChRbrace: push_token(KindRbrace, OpNone, s, e, ln);
            ChStar:   push_token(KindOper, OpMul, s, e, ln);
            ChSlash:  push_token(KindOper, OpDiv, s, e, ln);
            ChPlus:   push_token(KindOper, OpAdd, s, e, ln);
            ChMinus:  push_token(KindOper, OpSub, s, e, ln);
            ChCaret:  push_token(KindOper, OpPow, s, e, ln);
            ChEqual: begin
                scan_mode_q = M_EQ;
                tok_start_q = s;
            end
            ChLess: begin
                scan_mode_q = M_LT;
                tok_start_q = s;
            end
            ChGreat: begin
                scan_mode_q = M_GT;
                tok_start_q = s;
            end
            ChBang: begin
                scan_mode_q = M_BANG;
                tok_start_q = s;
            end
            default: begin
                push_token(KindError, OpNone, s, e, ln);
                scan_mode_q = M_DEAD;
            end
        endcase
    endfunction

    function automatic void scan_step(logic act, logic [7:0] c, logic [15:0] ln);
        logic [ColW-1:0] pos;
        logic [ColW-1:0] e2;
        bit              consumed;
        step_tokens.delete();
        pos = column_q;
        if (act) begin
            close_pending(pos, ln);
            push_token(KindEol, OpNone, sat_start(pos), pos, ln);
            scan_mode_q = M_IDLE;
            tok_start_q = '0;
            column_q    = '0;
        end else begin
            consumed = 1'b0;
            e2 = sat_end(pos + 1);
            case (scan_mode_q)
                M_IDENT: consumed = is_name_ch(c);
                M_INT: begin
                    if (c == ChDot) begin
                        scan_mode_q = M_FRAC;
                        consumed = 1'b1;
                    end else begin
                        consumed = is_digit_ch(c);
                    end
                end
                M_FRAC: consumed = is_digit_ch(c);
                M_EQ, M_LT, M_GT: begin
                    if (c == ChEqual) begin
                        push_token(KindOper, (scan_mode_q == M_EQ) ? OpEq :
                                   (scan_mode_q == M_LT) ? OpLe : OpGe, tok_start_q, e2, ln);
                        scan_mode_q = M_IDLE;
                        consumed = 1'b1;
                    end
                end
                M_BANG: begin
                    if (c == ChEqual) begin
                        push_token(KindOper, OpNe, tok_start_q, e2, ln);
                        scan_mode_q = M_IDLE;
                    end else begin
                        // lone bang: error on the bang, rest of line dropped
                        push_token(KindError, OpNone, tok_start_q, sat_end(tok_start_q + 1), ln);
                        scan_mode_q = M_DEAD;
                    end
                    consumed = 1'b1;
                end
                M_COMMENT, M_DEAD: consumed = 1'b1;
                default: scan_mode_q = M_IDLE;
            endcase
            if (!consumed) begin
                close_pending(pos, ln);
                start_fresh(c, pos, ln);
            end
            column_q = e2;
        end
        if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    function automatic bit field_differs(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] pick_char(string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            scan_step(in_ch.data.action, in_ch.data.char_code, in_ch.data.line_no);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        bit        bad;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            tokens_seen++;
            if (got.end_col == ColMax) capped_tokens++;
            if (expected_tokens.size() == 0) begin
                $display("%0t: token with nothing expected, actual %p", $time, got);
                mismatches++;
            end else begin
                want = expected_tokens.pop_front();
                bad = field_differs("token_kind", want.token_kind, got.token_kind)
                    | field_differs("op_code", want.op_code, got.op_code)
                    | field_differs("start_col", want.start_col, got.start_col)
                    | field_differs("end_col", want.end_col, got.end_col)
                    | field_differs("token_line", want.token_line, got.token_line)
                    | field_differs("last_of_run", want.last_of_run, got.last_of_run);
                if (bad) mismatches++;
            end
        end
    end

    // output side: random stalls plus one long hold on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                out_ch.ready = ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
            $display("%0t: no item moved for %0d cycles", $time, StallLimit);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(logic act, logic [7:0] c, logic [15:0] ln);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = '{action: act, char_code: c, line_no: ln};
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        items_sent++;
        chars_in_line = act ? 0 : chars_in_line + 1;
    endtask

    task automatic send_text(string txt, logic [15:0] ln);
        for (int i = 0; i < txt.len(); i++) send_item(1'b0, txt[i], ln);
    endtask

    task automatic end_line(logic [15:0] ln);
        send_item(1'b1, 8'($urandom_range(0, 255)), ln);
        lines_sent++;
    endtask

    // one lexeme; clean ones draw no comment, lone bang or stray byte
    task automatic send_random_token(bit clean, logic [15:0] ln);
        logic [7:0] seq[$];
        int         pick;
        pick = clean ? $urandom_range(0, 10) : $urandom_range(0, 15);
        case (pick)
            0, 1, 2, 3: begin
                seq.push_back(pick_char(Letters));
                repeat ($urandom_range(0, 5)) seq.push_back(pick_char(NameChars));
            end
            4, 5: begin
                repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(ChZero, ChNine)));
                if ($urandom_range(0, 1)) begin
                    seq.push_back(ChDot);
                    repeat ($urandom_range(0, 3))
                        seq.push_back(8'($urandom_range(ChZero, ChNine)));
                end
            end
            6: seq.push_back($urandom_range(0, 2) ? ChSpace : 8'($urandom_range(ChTab, ChCr)));
            7: seq.push_back(pick_char(SingleOps));
            8: begin
                seq.push_back(pick_char(PairLeads));
                seq.push_back(ChEqual);
            end
            9, 10: seq.push_back(pick_char(Punct));
            11: begin
                seq.push_back(ChLbrack);
                repeat ($urandom_range(0, 4)) seq.push_back(8'($urandom_range(0, 255)));
            end
            12: seq.push_back(ChBang);
            13: seq.push_back(8'($urandom_range(0, 255)));
            14: seq.push_back($urandom_range(0, 1) ? ChDot : ChQuote);
            default: seq.push_back(8'($urandom_range(128, 255)));
        endcase
        foreach (seq[i]) send_item(1'b0, seq[i], ln);
    endtask

    task automatic send_random_line(bit clean);
        logic [15:0] ln;
        bit          drift;
        ln    = 16'($urandom);
        drift = ($urandom_range(0, 9) == 0);
        repeat ($urandom_range(0, 10)) begin
            send_random_token(clean, ln);
            // open tokens then close under a later line number
            if (drift) ln = 16'($urandom);
        end
        end_line(ln);
    endtask

    task automatic test_directed_lines();
        send_text("a'9==1.5=", 16'hFFFF);
        end_line(16'hFFFF);
        send_text("(){};,#*/+-^>=<!=[z", 16'h0000);
        end_line(16'h0000);
        send_item(1'b0, ChGreat, 16'd1);
        send_item(1'b0, 8'h00, 16'd1);
        end_line(16'd1);
        send_text("!x", 16'd2);
        end_line(16'd2);
        send_text("!", 16'd3);
        end_line(16'd4);
        send_item(1'b0, 8'hFF, 16'd5);
        end_line(16'd5);
    endtask

    task automatic test_random_lines(int n_items);
        int first;
        first = items_sent;
        while (items_sent - first < n_items) send_random_line($urandom_range(0, 99) < 70);
    endtask

    task automatic test_output_backpressure();
        logic [15:0] ln;
        ln = 16'($urandom);
        hold_request = HoldCycles;
        // '=' then ';' gives two tokens on the ';' item, filling the result register fast
        repeat (20) begin
            send_item(1'b0, ChEqual, ln);
            send_item(1'b0, ChSemi, ln);
        end
        end_line(ln);
    endtask

    task automatic test_column_saturation();
        logic [15:0] ln;
        ln = 16'($urandom);
        while (chars_in_line < MaxLine - 12) send_random_token(1'b1, ln);
        send_text(" Long_ident_x 12.5 (<=>=!", ln);
        end_line(ln);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_lines();
        test_random_lines(50);

        src_idle_pct = 63;
        snk_idle_pct = 30;
        test_output_backpressure();
        test_random_lines(50);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_column_saturation();
        test_random_lines(50);
        in_ch.valid = 1'b0;

        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Scanned %0d items in %0d lines; %0d tokens checked, %0d at the column cap.",
                 items_sent, lines_sent, tokens_seen, capped_tokens);
        $display("Idle mixes 30/63, 63/30 and none, with one %0d-cycle output hold.",
                 HoldCycles);
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== line_token_scanner_core.f =====
hw/rtl/lts_pkg.sv
hw/rtl/lts_if.sv
hw/rtl/lts_step.sv
hw/rtl/line_token_scanner_core.sv
tb/testbench.sv
